// ===== hdl/ait_pkg.sv =====
// Package for the aging identifier table: state and status codes, field widths
// and the per-slot result record passed from the slot unit to the sequencer.
// No dependencies.
package ait_pkg;

    localparam int ID_W   = 32;
    localparam int LIFE_W = 8;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [LIFE_W-1:0] LIFE_RESET = 8'd5;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic REG_LIFETIME = 1'b0;

    localparam logic [1:0] STS_PRESENT  = 2'd0;
    localparam logic [1:0] STS_INSERTED = 2'd1;
    localparam logic [1:0] STS_FULL     = 2'd2;
    localparam logic [1:0] STS_TICK     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic              hit;
        logic              free;
        logic              wr_life;
        logic              expire;
        logic [LIFE_W-1:0] life_next;
    } t_slot_res;

endpackage

// ===== hdl/ait_slot_unit.sv =====
// Shared slot unit of the aging identifier table: compares one stored entry
// against the search key, or ages its lifetime on a tick.
// Depends on ait_pkg.
module ait_slot_unit (
    input  logic                      i_tick,
    input  logic                      i_valid,
    input  logic [ait_pkg::ID_W-1:0]   i_stored_id,
    input  logic [ait_pkg::ID_W-1:0]   i_key_id,
    input  logic [ait_pkg::LIFE_W-1:0] i_life,
    output ait_pkg::t_slot_res        o_res
);
    import ait_pkg::*;

    logic [LIFE_W-1:0] w_life_eff;

    // An entry that is not valid has a lifetime of zero.
    assign w_life_eff = i_valid ? i_life : '0;

    always_comb begin
        o_res.hit       = (i_tick == ACT_ADD) && i_valid && (i_stored_id == i_key_id);
        o_res.free      = (i_tick == ACT_ADD) && !i_valid;
        o_res.wr_life   = (i_tick == ACT_TICK) && (w_life_eff != '0);
        o_res.life_next = w_life_eff - LIFE_W'(1);
        o_res.expire    = (i_tick == ACT_TICK) && (w_life_eff == LIFE_W'(1));
    end

endmodule

// ===== hdl/aging_id_table.sv =====
// Top level of the aging identifier table: sequencer, entry memories and
// configuration port.
// Depends on ait_pkg and ait_slot_unit.
//
// Usage: an input beat carries an identifier in tdata and the action in tuser
// (add or tick). The block walks every slot once through one shared slot unit,
// one slot per cycle, and returns exactly one result beat: status in tuser,
// slot index, occupancy and expired count in tdata.
// The walk over the entry memories, a finish state and the load into the output
// register lie between the accepting edge and the result beat being presented;
// the ready line is high again in the cycle after the result is loaded, so the
// block takes no new beat while one is still being walked or loaded.
// When the receiver stalls, the finished result waits in the output register
// and the block takes the next input beat meanwhile; a second result waits in
// the sequencer until the output register is free.
// Reset clears all valid marks, the occupancy count and the handshakes, and
// sets the lifetime register to 5. The identifier and lifetime memories are
// not cleared; an entry is only read through its valid mark.
// The lifetime register lies at byte address 0 of the APB port.
module aging_id_table #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [ait_pkg::ID_W-1:0]    i_s_tdata,  // [31:0] entry_id
    input  logic                       i_s_tuser,  // [0] action
    // Result stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [15:0]                o_m_tdata,  // [3:0] slot_index, [8:4] occupancy,
                                                   // [13:9] expired_count, [15:14] zero
    output logic [1:0]                 o_m_tuser,  // [1:0] status
    // Configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ait_pkg::CFG_AW-1:0]  paddr,
    input  logic [ait_pkg::CFG_DW-1:0]  pwdata,
    output logic [ait_pkg::CFG_DW-1:0]  prdata,
    output logic                       pready
);
    import ait_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_state r_state, n_state;

    logic [CW-1:0]     r_idx;
    logic              r_pv;
    logic [IW-1:0]     r_pidx;
    logic              r_tick;
    logic [ID_W-1:0]   r_key;
    logic              r_found;
    logic [IW-1:0]     r_hit_idx;
    logic              r_free_found;
    logic [IW-1:0]     r_free_idx;
    logic [CW-1:0]     r_exp;
    logic [CW-1:0]     r_count;
    logic [ENTRIES-1:0] r_valid;
    logic [LIFE_W-1:0] r_life_cfg;
    logic [ID_W-1:0]   r_id_rd;
    logic [LIFE_W-1:0] r_lt_rd;
    logic [1:0]        r_res_status;
    logic [IW-1:0]     r_res_slot;
    logic              r_m_tvalid;
    logic [15:0]       r_m_tdata;
    logic [1:0]        r_m_tuser;

    logic [ID_W-1:0]   r_id_mem [ENTRIES];
    logic [LIFE_W-1:0] r_lt_mem [ENTRIES];

    logic              w_accept;
    logic              w_scan_last;
    logic              w_out_free;
    logic              w_scan;
    logic              w_finish;
    logic              w_load;
    logic              w_insert;
    logic [LIFE_W-1:0] w_ins_life;
    t_slot_res         w_res;
    logic              w_lt_we;
    logic [IW-1:0]     w_lt_waddr;
    logic [LIFE_W-1:0] w_lt_wdata;
    logic              w_cfg_wr;
    logic [IW+SLOT_W-1:0] w_slot_ext;
    logic [CW+CNT_W-1:0]  w_occ_ext;
    logic [CW+CNT_W-1:0]  w_exp_ext;

    ait_slot_unit u_slot (
        .i_tick      (r_tick),
        .i_valid     (r_valid[r_pidx]),
        .i_stored_id (r_id_rd),
        .i_key_id    (r_key),
        .i_life      (r_lt_rd),
        .o_res       (w_res)
    );

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_scan_last = (r_idx == CW'(ENTRIES));
    assign w_out_free  = !r_m_tvalid || i_m_tready;
    assign w_insert    = w_finish && (r_tick == ACT_ADD) && !r_found && r_free_found;
    assign w_ins_life  = (r_life_cfg == '0) ? LIFE_W'(1) : r_life_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        w_scan     = 1'b0;
        w_finish   = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_scan = 1'b1;
                if (w_scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                w_finish = 1'b1;
                n_state  = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer control and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv         <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_exp        <= '0;
            r_count      <= '0;
            r_valid      <= '0;
            r_idx        <= '0;
        end else begin
            if (w_accept) begin
                r_idx        <= '0;
                r_pv         <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_exp        <= '0;
            end else if (w_scan) begin
                r_pv <= !w_scan_last;
                if (!w_scan_last) begin
                    r_idx <= r_idx + CW'(1);
                end
            end

            if (r_pv && w_res.hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (r_pv && w_res.free && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (r_pv && w_res.expire) begin
                r_valid[r_pidx] <= 1'b0;
                r_count         <= r_count - CW'(1);
                r_exp           <= r_exp + CW'(1);
            end
            if (w_insert) begin
                r_valid[r_free_idx] <= 1'b1;
                r_count             <= r_count + CW'(1);
            end
        end
    end

    // Payload registers of the walk.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tick <= i_s_tuser;
            r_key  <= i_s_tdata;
        end
        if (w_scan) begin
            r_pidx <= r_idx[IW-1:0];
        end
        if (r_pv && w_res.hit && !r_found) begin
            r_hit_idx <= r_pidx;
        end
        if (r_pv && w_res.free && !r_free_found) begin
            r_free_idx <= r_pidx;
        end
        if (w_finish) begin
            if (r_tick == ACT_TICK) begin
                r_res_status <= STS_TICK;
                r_res_slot   <= '0;
            end else if (r_found) begin
                r_res_status <= STS_PRESENT;
                r_res_slot   <= r_hit_idx;
            end else if (r_free_found) begin
                r_res_status <= STS_INSERTED;
                r_res_slot   <= r_free_idx;
            end else begin
                r_res_status <= STS_FULL;
                r_res_slot   <= '0;
            end
        end
    end

    always_comb begin
        w_lt_we    = 1'b0;
        w_lt_waddr = r_pidx;
        w_lt_wdata = w_res.life_next;
        if (w_insert) begin
            w_lt_we    = 1'b1;
            w_lt_waddr = r_free_idx;
            w_lt_wdata = w_ins_life;
        end else if (r_pv && w_res.wr_life) begin
            w_lt_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan && !w_scan_last) begin
            r_id_rd <= r_id_mem[r_idx[IW-1:0]];
            r_lt_rd <= r_lt_mem[r_idx[IW-1:0]];
        end
        if (w_insert) begin
            r_id_mem[r_free_idx] <= r_key;
        end
        if (w_lt_we) begin
            r_lt_mem[w_lt_waddr] <= w_lt_wdata;
        end
    end

    // Output register.
    assign w_slot_ext = {{SLOT_W{1'b0}}, r_res_slot};
    assign w_occ_ext  = {{CNT_W{1'b0}}, r_count};
    assign w_exp_ext  = {{CNT_W{1'b0}}, r_exp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_tuser <= r_res_status;
            r_m_tdata <= {2'b00, w_exp_ext[CNT_W-1:0], w_occ_ext[CNT_W-1:0],
                          w_slot_ext[SLOT_W-1:0]};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_LIFETIME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life_cfg <= LIFE_RESET;
        end else if (w_cfg_wr) begin
            r_life_cfg <= pwdata[LIFE_W-1:0];
        end
    end

    assign prdata = (paddr[CFG_AW-1] == REG_LIFETIME) ?
                    {{(CFG_DW-LIFE_W){1'b0}}, r_life_cfg} : '0;

`ifndef SYNTH
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("occupancy count differs from the number of valid entries");

    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_SCAN && r_idx == '0))
        else $error("accepted beat did not start a walk from slot zero");

    a_tick_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == STS_TICK) |-> (o_m_tdata[SLOT_W-1:0] == '0))
        else $error("tick result carries a nonzero slot index");
`endif

endmodule
